/* hw/rtl/mtfa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mtfa_pkg
// shared types, widths and helpers of the tangent frame accumulator
// ----------------------------------------------------------------------------
package mtfa_pkg;

  localparam int VI_W             = 10;
  localparam int COORD_W          = 16;
  localparam int OUT_W            = 16;
  localparam int SUM_W            = 18;
  localparam int WIDE_W           = 36;
  localparam int IN_DATA_W        = 120;
  localparam int OUT_DATA_W       = 96;
  localparam int QDEPTH           = 4;
  localparam int VERTEX_COUNT_DEF = 1024;
  localparam int SHORT_SQ         = 2684;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_TRI   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef struct packed {
    op_t                          op;
    logic [VI_W-1:0]              vi;
    logic [2:0][COORD_W-1:0]      pos;
    logic [1:0][COORD_W-1:0]      tex;
    logic [2:0][VI_W-1:0]         corner;
    logic                         vi_ok;
    logic                         tri_ok;
  } q_item_t;

  typedef struct packed {
    logic [1:0][COORD_W-1:0] tex;
    logic [2:0][COORD_W-1:0] pos;
  } vert_t;

  typedef struct packed {
    logic [2:0][SUM_W-1:0] b;
    logic [2:0][SUM_W-1:0] t;
  } sums_t;

  typedef logic [2:0][WIDE_W-1:0] vec_t;
  typedef logic [2:0][OUT_W-1:0]  ovec_t;

  // saturating add of a q1.14 unit component into a q3.14 sum
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                               input logic [OUT_W-1:0] d);
    logic signed [SUM_W:0] r;
    r = $signed({s[SUM_W-1], s}) + $signed({{(SUM_W+1-OUT_W){d[OUT_W-1]}}, d});
    if (r > $signed({2'b00, {(SUM_W-1){1'b1}}})) begin
      sat_add = {1'b0, {(SUM_W-1){1'b1}}};
    end else if (r < $signed({2'b11, {(SUM_W-1){1'b0}}})) begin
      sat_add = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sat_add = r[SUM_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/mtfa_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mtfa_front
// accepts input items, checks index ranges and queues them for the back end
// ----------------------------------------------------------------------------
module mtfa_front import mtfa_pkg::*; #(
  parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
  input  wire logic [1:0]           s_axis_tuser,
  output logic                      q_valid,
  input  wire logic                 q_ready,
  output q_item_t                   q_item
);

  localparam int PW = $clog2(QDEPTH);

  q_item_t          qmem [QDEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;
  q_item_t          in_item;
  logic             push;
  logic             pop;

  always_comb begin
    in_item.op        = op_t'(s_axis_tuser);
    in_item.vi        = s_axis_tdata[9:0];
    in_item.pos[0]    = s_axis_tdata[25:10];
    in_item.pos[1]    = s_axis_tdata[41:26];
    in_item.pos[2]    = s_axis_tdata[57:42];
    in_item.tex[0]    = s_axis_tdata[73:58];
    in_item.tex[1]    = s_axis_tdata[89:74];
    in_item.corner[0] = s_axis_tdata[99:90];
    in_item.corner[1] = s_axis_tdata[109:100];
    in_item.corner[2] = s_axis_tdata[119:110];
    in_item.vi_ok     = (32'(in_item.vi) < VERTEX_COUNT);
    in_item.tri_ok    = (32'(in_item.corner[0]) < VERTEX_COUNT) &&
                        (32'(in_item.corner[1]) < VERTEX_COUNT) &&
                        (32'(in_item.corner[2]) < VERTEX_COUNT);
  end

  assign s_axis_tready = en && (count != (PW+1)'(QDEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (count != '0);
  assign pop           = q_valid && q_ready;
  assign q_item        = qmem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/mtfa_norm.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mtfa_norm
// iterative q1.14 normalizer: align, sum of squares, bitwise sqrt, 3-lane divide
// ----------------------------------------------------------------------------
module mtfa_norm import mtfa_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire vec_t vec_in,
  output logic      done,
  output logic      ok,
  output ovec_t     vec_out
);

  typedef enum logic [2:0] {
    N_IDLE, N_CHECK, N_SHIFT, N_SQ, N_SQRT, N_DPREP, N_DIV, N_DONE
  } nstate_t;

  nstate_t                 state;
  logic [2:0][WIDE_W-1:0]  m;
  logic [2:0]              neg;
  logic [WIDE_W-1:0]       mx;
  logic [59:0]             prod;
  logic [61:0]             len;
  logic [4:0]              cnt;
  logic [63:0]             sx;
  logic [63:0]             sr;
  logic [63:0]             sb;
  logic [63:0]             st;
  logic [2:0][45:0]        rem;
  logic [44:0]             dv;
  logic [2:0][14:0]        q;

  always_comb begin
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
  end

  assign st = sr + sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done  <= 1'b0;
      ok    <= 1'b0;
      cnt   <= '0;
    end else begin
      case (state)
        N_IDLE: begin
          done <= 1'b0;
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              neg[i] <= vec_in[i][WIDE_W-1];
              m[i]   <= vec_in[i][WIDE_W-1] ? (~vec_in[i] + 1'b1) : vec_in[i];
            end
            state <= N_CHECK;
          end
        end
        N_CHECK: begin
          if (mx == '0) begin
            ok    <= 1'b0;
            done  <= 1'b1;
            state <= N_DONE;
          end else begin
            state <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          // bring the largest magnitude into [2^29, 2^30)
          if (mx[WIDE_W-1:34] != '0) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] >> 4;
          end else if (mx[WIDE_W-1:30] != '0) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
          end else if (mx[WIDE_W-1:25] == '0) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] << 4;
          end else if (mx[29] == 1'b0) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] << 1;
          end else begin
            len   <= '0;
            cnt   <= '0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          if (cnt != 5'd3) begin
            prod <= m[cnt[1:0]][29:0] * m[cnt[1:0]][29:0];
          end
          if (cnt != 5'd0) begin
            len <= len + 62'(prod);
          end
          if (cnt == 5'd3) begin
            sx    <= 64'(len + 62'(prod));
            sr    <= '0;
            sb    <= 64'h4000_0000_0000_0000;
            cnt   <= '0;
            state <= N_SQRT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        N_SQRT: begin
          if (sx >= st) begin
            sx <= sx - st;
            sr <= (sr >> 1) + sb;
          end else begin
            sr <= sr >> 1;
          end
          sb  <= sb >> 2;
          cnt <= cnt + 1'b1;
          if (cnt == 5'd31) state <= N_DPREP;
        end
        N_DPREP: begin
          for (int i = 0; i < 3; i++) begin
            rem[i] <= {2'b00, m[i][29:0], 14'b0} + 46'(sr[30:1]);
            q[i]   <= '0;
          end
          dv    <= {sr[30:0], 14'b0};
          cnt   <= '0;
          state <= N_DIV;
        end
        N_DIV: begin
          for (int i = 0; i < 3; i++) begin
            if (rem[i] >= {1'b0, dv}) begin
              rem[i] <= rem[i] - {1'b0, dv};
              q[i]   <= {q[i][13:0], 1'b1};
            end else begin
              q[i] <= {q[i][13:0], 1'b0};
            end
          end
          dv  <= dv >> 1;
          cnt <= cnt + 1'b1;
          if (cnt == 5'd14) begin
            state <= N_DONE;
            done  <= 1'b1;
            ok    <= 1'b1;
          end
        end
        N_DONE: begin
          done  <= 1'b0;
          state <= N_IDLE;
        end
        default: state <= N_IDLE;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vec_out[i] = neg[i] ? (~{1'b0, q[i]} + 1'b1) : {1'b0, q[i]};
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/mtfa_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mtfa_back
// sequencer: vertex and sum memories, shared multiplier, frame updates, reads
// ----------------------------------------------------------------------------
module mtfa_back import mtfa_pkg::*; #(
  parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_valid,
  output logic                       q_ready,
  input  wire q_item_t               q_item,
  output logic                       init_done,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  localparam int Depth = (VERTEX_COUNT < (1 << VI_W)) ? VERTEX_COUNT : (1 << VI_W);
  localparam int AW    = $clog2(Depth);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RDA, S_RDB, S_RDC, S_CAPC, S_DIFF, S_MUL, S_DETCHK,
    S_NSTART, S_NWAIT, S_UPDRD, S_UPDWR, S_RDS, S_CAPS, S_SQ, S_CHK, S_EMIT
  } state_t;

  typedef enum logic [1:0] {P_TT, P_TB, P_RD} purpose_t;

  state_t               state;
  purpose_t             purpose;
  q_item_t              cur;
  logic [AW-1:0]        ccnt;

  vert_t                vmem [Depth];
  logic [AW-1:0]        vraddr;
  vert_t                vrdata;
  logic                 vwe;
  vert_t                vwdata;

  sums_t                smem [Depth];
  logic [AW-1:0]        sraddr;
  sums_t                srdata;
  logic                 swe;
  logic [AW-1:0]        swaddr;
  sums_t                swdata;
  sums_t                upd;

  vert_t                va;
  vert_t                vb;
  vert_t                vc;
  logic signed [16:0]   e1 [3];
  logic signed [16:0]   e2 [3];
  logic signed [16:0]   du1, dv1, du2, dv2;
  logic signed [17:0]   mul_a, mul_b;
  logic signed [35:0]   p;
  logic signed [35:0]   p1;
  logic signed [35:0]   res [7];
  logic [2:0]           j;
  logic [1:0]           ph;
  logic                 det_neg;
  logic [1:0]           k;
  logic [1:0]           cnt;
  logic                 rv;
  sums_t                sv;
  logic [2:0][SUM_W-1:0] sel;
  logic [37:0]          acc;

  vec_t                 nvec;
  logic                 nstart;
  logic                 ndone;
  logic                 nok;
  ovec_t                nout;
  ovec_t                ut, ub, rt, rb;
  logic                 tok, bok;

  mtfa_norm u_norm (
    .clk     (clk),
    .rst     (rst),
    .start   (nstart),
    .vec_in  (nvec),
    .done    (ndone),
    .ok      (nok),
    .vec_out (nout)
  );

  assign nstart  = (state == S_NSTART);
  assign q_ready = (state == S_IDLE);
  assign sel     = rv ? sv.b : sv.t;

  // memories
  assign vwe         = (state == S_IDLE) && q_valid && (q_item.op == OP_LOAD) &&
                       q_item.vi_ok;
  assign vwdata.pos  = q_item.pos;
  assign vwdata.tex  = q_item.tex;

  always_comb begin
    case (state)
      S_RDA:   vraddr = cur.corner[0][AW-1:0];
      S_RDB:   vraddr = cur.corner[1][AW-1:0];
      default: vraddr = cur.corner[2][AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (vwe) vmem[q_item.vi[AW-1:0]] <= vwdata;
    vrdata <= vmem[vraddr];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      upd.t[i] = tok ? sat_add(srdata.t[i], ut[i]) : srdata.t[i];
      upd.b[i] = bok ? sat_add(srdata.b[i], ub[i]) : srdata.b[i];
    end
  end

  always_comb begin
    sraddr = (state == S_UPDRD) ? cur.corner[k][AW-1:0] : cur.vi[AW-1:0];
    swe    = (state == S_CLEAR) || (state == S_UPDWR);
    swaddr = (state == S_CLEAR) ? ccnt : cur.corner[k][AW-1:0];
    swdata = (state == S_CLEAR) ? '0 : upd;
  end

  always_ff @(posedge clk) begin
    if (swe) smem[swaddr] <= swdata;
    srdata <= smem[sraddr];
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_MUL) begin
      if (j == 3'd0) begin
        mul_a = (ph == 2'd0) ? {du1[16], du1} : {du2[16], du2};
        mul_b = (ph == 2'd0) ? {dv2[16], dv2} : {dv1[16], dv1};
      end else if (j < 3'd4) begin
        mul_a = (ph == 2'd0) ? {dv2[16], dv2} : {dv1[16], dv1};
        mul_b = (ph == 2'd0) ? {e1[2'(j - 3'd1)][16], e1[2'(j - 3'd1)]}
                             : {e2[2'(j - 3'd1)][16], e2[2'(j - 3'd1)]};
      end else begin
        mul_a = (ph == 2'd0) ? {du1[16], du1} : {du2[16], du2};
        mul_b = (ph == 2'd0) ? {e2[2'(j - 3'd4)][16], e2[2'(j - 3'd4)]}
                             : {e1[2'(j - 3'd4)][16], e1[2'(j - 3'd4)]};
      end
    end else begin
      case (cnt)
        2'd0:    mul_a = $signed(sel[0]);
        2'd1:    mul_a = $signed(sel[1]);
        default: mul_a = $signed(sel[2]);
      endcase
      mul_b = mul_a;
    end
  end

  always_ff @(posedge clk) begin
    p <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      ccnt          <= '0;
      init_done     <= 1'b0;
      m_axis_tvalid <= 1'b0;
      purpose       <= P_TT;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != S_EMIT)) m_axis_tvalid <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (ccnt == AW'(Depth - 1)) begin
            ccnt      <= '0;
            init_done <= 1'b1;
            state     <= S_IDLE;
          end else begin
            ccnt <= ccnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            case (q_item.op)
              OP_LOAD:  state <= S_IDLE;
              OP_TRI:   state <= q_item.tri_ok ? S_RDA : S_IDLE;
              OP_READ: begin
                if (q_item.vi_ok) begin
                  state <= S_RDS;
                end else begin
                  rt    <= '0;
                  rb    <= '0;
                  state <= S_EMIT;
                end
              end
              OP_CLEAR: begin
                ccnt  <= '0;
                state <= S_CLEAR;
              end
              default:  state <= S_IDLE;
            endcase
          end
        end
        S_RDA: state <= S_RDB;
        S_RDB: begin
          va    <= vrdata;
          state <= S_RDC;
        end
        S_RDC: begin
          vb    <= vrdata;
          state <= S_CAPC;
        end
        S_CAPC: begin
          vc    <= vrdata;
          state <= S_DIFF;
        end
        S_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            e1[i] <= $signed({vb.pos[i][15], vb.pos[i]}) -
                     $signed({va.pos[i][15], va.pos[i]});
            e2[i] <= $signed({vc.pos[i][15], vc.pos[i]}) -
                     $signed({va.pos[i][15], va.pos[i]});
          end
          du1   <= $signed({1'b0, vb.tex[0]}) - $signed({1'b0, va.tex[0]});
          dv1   <= $signed({1'b0, vb.tex[1]}) - $signed({1'b0, va.tex[1]});
          du2   <= $signed({1'b0, vc.tex[0]}) - $signed({1'b0, va.tex[0]});
          dv2   <= $signed({1'b0, vc.tex[1]}) - $signed({1'b0, va.tex[1]});
          j     <= '0;
          ph    <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          // det, then tangent and bitangent components, each a - b
          case (ph)
            2'd0: ph <= 2'd1;
            2'd1: begin
              p1 <= p;
              ph <= 2'd2;
            end
            default: begin
              res[j] <= p1 - p;
              ph     <= 2'd0;
              if (j == 3'd6) begin
                state <= S_DETCHK;
              end else begin
                j <= j + 1'b1;
              end
            end
          endcase
        end
        S_DETCHK: begin
          if (res[0] == '0) begin
            state <= S_IDLE;
          end else begin
            det_neg <= res[0][35];
            for (int i = 0; i < 3; i++) begin
              nvec[i] <= res[0][35] ? (-res[1+i]) : res[1+i];
            end
            purpose <= P_TT;
            state   <= S_NSTART;
          end
        end
        S_NSTART: state <= S_NWAIT;
        S_NWAIT: begin
          if (ndone) begin
            case (purpose)
              P_TT: begin
                ut  <= nout;
                tok <= nok;
                for (int i = 0; i < 3; i++) begin
                  nvec[i] <= det_neg ? (-res[4+i]) : res[4+i];
                end
                purpose <= P_TB;
                state   <= S_NSTART;
              end
              P_TB: begin
                ub    <= nout;
                bok   <= nok;
                k     <= '0;
                state <= S_UPDRD;
              end
              default: begin
                if (!rv) begin
                  rt    <= nout;
                  rv    <= 1'b1;
                  cnt   <= '0;
                  state <= S_SQ;
                end else begin
                  rb    <= nout;
                  state <= S_EMIT;
                end
              end
            endcase
          end
        end
        S_UPDRD: state <= S_UPDWR;
        S_UPDWR: begin
          if (k == 2'd2) begin
            state <= S_IDLE;
          end else begin
            k     <= k + 1'b1;
            state <= S_UPDRD;
          end
        end
        S_RDS: state <= S_CAPS;
        S_CAPS: begin
          sv    <= srdata;
          rv    <= 1'b0;
          cnt   <= '0;
          state <= S_SQ;
        end
        S_SQ: begin
          // squared length of the selected sum
          if (cnt == 2'd0) begin
            acc <= '0;
          end else begin
            acc <= acc + {2'b00, p};
          end
          cnt <= cnt + 1'b1;
          if (cnt == 2'd3) state <= S_CHK;
        end
        S_CHK: begin
          if (acc < 38'(SHORT_SQ)) begin
            // short vector goes out unscaled
            if (!rv) begin
              for (int i = 0; i < 3; i++) rt[i] <= sel[i][OUT_W-1:0];
              rv    <= 1'b1;
              cnt   <= '0;
              state <= S_SQ;
            end else begin
              for (int i = 0; i < 3; i++) rb[i] <= sel[i][OUT_W-1:0];
              state <= S_EMIT;
            end
          end else begin
            for (int i = 0; i < 3; i++) begin
              nvec[i] <= {{(WIDE_W-SUM_W){sel[i][SUM_W-1]}}, sel[i]};
            end
            purpose <= P_RD;
            state   <= S_NSTART;
          end
        end
        S_EMIT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {rb, rt};
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/mesh_tangent_frame_accumulator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mesh_tangent_frame_accumulator
// per-vertex tangent and bitangent accumulation in fixed point
// ----------------------------------------------------------------------------
// usage:
//   items enter on the s_axis stream; tuser carries the op (load vertex, add
//   triangle, read frame, clear sums), tdata the vertex and triangle fields.
//   a read item returns one item on m_axis with both frames in q1.14.
//   a 4-entry queue separates the input check from the sequencer, so items
//   are taken while earlier ones are still at work or a result waits.
// operation:
//   load: the vertex memory is written. add triangle: the determinant and
//   six frame components on the shared 18x18 multiplier, two passes through
//   the normalizer (32-step square root, 15-step divide), and a sum memory
//   read-modify-write per corner. read frame: a normalizer pass per long frame,
//   then output. clear: one sum entry per cycle over min(VERTEX_COUNT, 1024) entries.
// reset:
//   synchronous, active high; afterwards the sum memory is swept to zero,
//   one entry per cycle over min(VERTEX_COUNT, 1024) entries, with s_axis_tready
//   low. vertex memory is not cleared.
// stall:
//   a result is held in the output register until m_axis_tready; the
//   sequencer waits on the next read only, and the queue keeps filling.
// ----------------------------------------------------------------------------
module mesh_tangent_frame_accumulator import mtfa_pkg::*; #(
  parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v, corner_a, corner_b, corner_c
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op
  input  wire logic [1:0]            s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  // queue between front and back
  logic    q_valid;
  logic    q_ready;
  q_item_t q_item;
  // high once the power-on sum clear is finished
  logic    init_done;

  mtfa_front #(
    .VERTEX_COUNT (VERTEX_COUNT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .en            (init_done),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item)
  );

  mtfa_back #(
    .VERTEX_COUNT (VERTEX_COUNT)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item),
    .init_done     (init_done),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
`default_nettype wire
